// ===== design/ps2mct_pkg.sv =====
// shared types, codes and reset constants for the ps2 mouse cursor tracker
`default_nettype none
package ps2mct_pkg;

  localparam int COORD_BITS_DEF = 12;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_BYTE    = 2'd0;
  localparam mode_t MODE_PRESS   = 2'd1;
  localparam mode_t MODE_RELEASE = 2'd2;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_SCREEN_WIDTH   = 2'd0;
  localparam reg_idx_t REG_SCREEN_HEIGHT  = 2'd1;
  localparam reg_idx_t REG_DELTA_LIMIT    = 2'd2;
  localparam reg_idx_t REG_DEBOUNCE_TICKS = 2'd3;

  localparam int CFG_DATA_BITS = 16;

  localparam logic [12:0] SCREEN_WIDTH_RST   = 13'd800;
  localparam logic [12:0] SCREEN_HEIGHT_RST  = 13'd600;
  localparam logic [7:0]  DELTA_LIMIT_RST    = 8'd45;
  localparam logic [15:0] DEBOUNCE_TICKS_RST = 16'd10;

  localparam int POS_X_RST = 400;
  localparam int POS_Y_RST = 300;

  localparam logic [7:0] HDR_SYNC   = 8'h08;
  localparam logic [7:0] HDR_XSIGN  = 8'h10;
  localparam logic [7:0] HDR_YSIGN  = 8'h20;
  localparam logic [7:0] HDR_OVFL   = 8'hC0;
  localparam logic [7:0] HDR_LEFT   = 8'h01;

  typedef struct packed {
    logic [12:0] screen_width;
    logic [12:0] screen_height;
    logic [7:0]  delta_limit;
    logic [15:0] debounce_ticks;
  } cfg_t;

  typedef struct packed {
    logic left_button;
    logic event_flag;
    logic packet_done;
  } flags_t;

endpackage
`default_nettype wire

// ===== design/ps2mct_cfg.sv =====
// configuration register file
`default_nettype none
module ps2mct_cfg (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire ps2mct_pkg::reg_idx_t                 cfg_index_i,
  input  wire logic [ps2mct_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  output ps2mct_pkg::cfg_t                          cfg_o
);
  import ps2mct_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SCREEN_WIDTH:   cfg_d.screen_width   = cfg_data_i[12:0];
        REG_SCREEN_HEIGHT:  cfg_d.screen_height  = cfg_data_i[12:0];
        REG_DELTA_LIMIT:    cfg_d.delta_limit    = cfg_data_i[7:0];
        REG_DEBOUNCE_TICKS: cfg_d.debounce_ticks = cfg_data_i[15:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_width   <= SCREEN_WIDTH_RST;
      cfg_q.screen_height  <= SCREEN_HEIGHT_RST;
      cfg_q.delta_limit    <= DELTA_LIMIT_RST;
      cfg_q.debounce_ticks <= DEBOUNCE_TICKS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ===== design/ps2mct_step.sv =====
// packet assembly, cursor update and button event state
`default_nettype none
module ps2mct_step #(
  parameter int COORD_BITS = ps2mct_pkg::COORD_BITS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    fire_i,
  input  wire ps2mct_pkg::mode_t       mode_i,
  input  wire logic [7:0]              rx_byte_i,
  input  wire logic                    data_ready_i,
  input  wire logic                    from_aux_i,
  input  wire logic [31:0]             now_tick_i,
  input  wire ps2mct_pkg::cfg_t        cfg_i,
  output logic [COORD_BITS-1:0]        cursor_x_o,
  output logic [COORD_BITS-1:0]        cursor_y_o,
  output ps2mct_pkg::flags_t           flags_o
);
  import ps2mct_pkg::*;

  localparam int SW = COORD_BITS + 2;
  localparam logic [16:0] CAP = 17'(1) << COORD_BITS;

  logic [1:0]            idx_q, idx_d;
  logic [7:0]            hdr_q, hdr_d;
  logic [7:0]            xb_q, xb_d;
  logic [COORD_BITS-1:0] px_q, px_d;
  logic [COORD_BITS-1:0] py_q, py_d;
  logic                  held_q, held_d;
  logic                  pressp_q, pressp_d;
  logic                  relp_q, relp_d;
  logic [31:0]           last_q, last_d;
  logic                  event_flag, packet_done;

  logic [16:0]           wsz, hsz, wext, hext, wm1, hm1;
  logic [COORD_BITS-1:0] wmax, hmax;
  logic signed [8:0]     dx, dy, dxz, dyz;
  logic signed [9:0]     lim, dxl, dyl;
  logic signed [SW-1:0]  sx, sy;
  logic [COORD_BITS-1:0] nx, ny;
  logic                  ovfl, btn;
  logic [31:0]           tick_gap;

  // screen extents, zero treated as one and capped at the coordinate range
  always_comb begin
    wsz  = {4'd0, cfg_i.screen_width};
    hsz  = {4'd0, cfg_i.screen_height};
    if (wsz == 17'd0) wsz = 17'd1;
    if (hsz == 17'd0) hsz = 17'd1;
    wext = (wsz > CAP) ? CAP : wsz;
    hext = (hsz > CAP) ? CAP : hsz;
    wm1  = wext - 17'd1;
    hm1  = hext - 17'd1;
    wmax = wm1[COORD_BITS-1:0];
    hmax = hm1[COORD_BITS-1:0];
  end

  // packet arithmetic, y byte is the current rx byte
  always_comb begin
    dx   = $signed({(hdr_q & HDR_XSIGN) != 8'd0, xb_q});
    dy   = $signed({(hdr_q & HDR_YSIGN) != 8'd0, rx_byte_i});
    ovfl = (hdr_q & HDR_OVFL) != 8'd0;
    btn  = (hdr_q & HDR_LEFT) != 8'd0;
    lim  = $signed({2'b00, cfg_i.delta_limit});

    dxz = dx;
    if ((px_q == '0 && dx < 0) || (px_q >= wmax && dx > 0)) dxz = '0;
    dyz = dy;
    if ((py_q == '0 && dy > 0) || (py_q >= hmax && dy < 0)) dyz = '0;

    dxl = 10'(dxz);
    if (dxl > lim) dxl = lim;
    else if (dxl < -lim) dxl = -lim;
    dyl = 10'(dyz);
    if (dyl > lim) dyl = lim;
    else if (dyl < -lim) dyl = -lim;
    if (ovfl) begin
      dxl = '0;
      dyl = '0;
    end

    sx = $signed({2'b00, px_q}) + SW'(dxl);
    sy = $signed({2'b00, py_q}) - SW'(dyl);

    if (sx < 0) nx = '0;
    else if (sx > $signed({2'b00, wmax})) nx = wmax;
    else nx = sx[COORD_BITS-1:0];
    if (sy < 0) ny = '0;
    else if (sy > $signed({2'b00, hmax})) ny = hmax;
    else ny = sy[COORD_BITS-1:0];
  end

  assign tick_gap = now_tick_i - last_q;

  always_comb begin
    idx_d       = idx_q;
    hdr_d       = hdr_q;
    xb_d        = xb_q;
    px_d        = px_q;
    py_d        = py_q;
    held_d      = held_q;
    pressp_d    = pressp_q;
    relp_d      = relp_q;
    last_d      = last_q;
    event_flag  = 1'b0;
    packet_done = 1'b0;
    case (mode_i)
      MODE_BYTE: begin
        if (data_ready_i && from_aux_i) begin
          if (idx_q == 2'd1) begin
            xb_d  = rx_byte_i;
            idx_d = 2'd2;
          end else if (idx_q == 2'd2) begin
            idx_d       = 2'd0;
            packet_done = 1'b1;
            if (btn && !held_q) pressp_d = 1'b1;
            if (!btn && held_q) relp_d = 1'b1;
            held_d = btn;
            px_d   = nx;
            py_d   = ny;
          end else if ((rx_byte_i & HDR_SYNC) != 8'd0) begin
            hdr_d = rx_byte_i;
            idx_d = 2'd1;
          end else begin
            idx_d = 2'd0;
          end
        end
      end
      MODE_PRESS: begin
        if (pressp_q) begin
          pressp_d = 1'b0;
          if (tick_gap >= {16'd0, cfg_i.debounce_ticks}) begin
            event_flag = 1'b1;
            last_d     = now_tick_i;
          end
        end
      end
      MODE_RELEASE: begin
        if (relp_q) begin
          relp_d     = 1'b0;
          event_flag = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      hdr_q    <= '0;
      xb_q     <= '0;
      px_q     <= COORD_BITS'(POS_X_RST);
      py_q     <= COORD_BITS'(POS_Y_RST);
      held_q   <= 1'b0;
      pressp_q <= 1'b0;
      relp_q   <= 1'b0;
      last_q   <= '0;
    end else if (fire_i) begin
      idx_q    <= idx_d;
      hdr_q    <= hdr_d;
      xb_q     <= xb_d;
      px_q     <= px_d;
      py_q     <= py_d;
      held_q   <= held_d;
      pressp_q <= pressp_d;
      relp_q   <= relp_d;
      last_q   <= last_d;
    end
  end

  assign cursor_x_o          = px_d;
  assign cursor_y_o          = py_d;
  assign flags_o.left_button = held_d;
  assign flags_o.event_flag  = event_flag;
  assign flags_o.packet_done = packet_done;

endmodule
`default_nettype wire

// ===== design/ps2_mouse_cursor_tracker.sv =====
// PS/2 mouse cursor tracker, request register, update step and result register
// Every request yields exactly one result. A request is taken into an input
// register, processed by the update step and written into the result
// register. One request can be accepted in every clock cycle unless a result
// waits under stall while the input register is full. The input
// register can hold one more request while a finished result waits under
// stall. There is no start-up delay after reset.
`default_nettype none
module ps2_mouse_cursor_tracker #(
  parameter int COORD_BITS = ps2mct_pkg::COORD_BITS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire ps2mct_pkg::reg_idx_t                 cfg_index_i,
  input  wire logic [ps2mct_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire ps2mct_pkg::mode_t                    mode_i,
  input  wire logic [7:0]                           rx_byte_i,
  input  wire logic                                 data_ready_i,
  input  wire logic                                 from_aux_i,
  input  wire logic [31:0]                          now_tick_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic [COORD_BITS-1:0]                     cursor_x_o,
  output logic [COORD_BITS-1:0]                     cursor_y_o,
  output logic                                      left_button_o,
  output logic                                      event_flag_o,
  output logic                                      packet_done_o
);
  import ps2mct_pkg::*;

  cfg_t cfg;

  logic        s1_valid_q, s1_valid_d;
  mode_t       mode_q;
  logic [7:0]  rx_q;
  logic        ready_q, aux_q;
  logic [31:0] now_q;

  logic                  out_valid_q, out_valid_d;
  logic [COORD_BITS-1:0] x_q, y_q, x_s, y_s;
  flags_t                flags_q, flags_s;

  logic out_free, fire, accept;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) s1_valid_d = 1'b1;
    else if (fire) s1_valid_d = 1'b0;
    out_valid_d = out_valid_q;
    if (fire) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= mode_i;
      rx_q    <= rx_byte_i;
      ready_q <= data_ready_i;
      aux_q   <= from_aux_i;
      now_q   <= now_tick_i;
    end
    if (fire) begin
      x_q     <= x_s;
      y_q     <= y_s;
      flags_q <= flags_s;
    end
  end

  ps2mct_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ps2mct_step #(
    .COORD_BITS (COORD_BITS)
  ) u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .mode_i       (mode_q),
    .rx_byte_i    (rx_q),
    .data_ready_i (ready_q),
    .from_aux_i   (aux_q),
    .now_tick_i   (now_q),
    .cfg_i        (cfg),
    .cursor_x_o   (x_s),
    .cursor_y_o   (y_s),
    .flags_o      (flags_s)
  );

  assign out_valid_o   = out_valid_q;
  assign cursor_x_o    = x_q;
  assign cursor_y_o    = y_q;
  assign left_button_o = flags_q.left_button;
  assign event_flag_o  = flags_q.event_flag;
  assign packet_done_o = flags_q.packet_done;

endmodule
`default_nettype wire

// ===== design/ps2mct_checker.sv =====
// port level checks for the cursor tracker and their bind
`default_nettype none
module ps2mct_checker #(
  parameter int COORD_BITS = ps2mct_pkg::COORD_BITS_DEF
) (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_stall_o,
  input wire logic                  out_valid_o,
  input wire logic                  out_stall_i,
  input wire logic [COORD_BITS-1:0] cursor_x_o,
  input wire logic                  event_flag_o,
  input wire logic                  packet_done_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped under stall");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(cursor_x_o) && $stable(packet_done_o))
    else $error("stalled result changed");

  // with no result pending the request side never stalls
  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("request stalled while result register empty");

  // an event query never completes a packet
  a_event_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(event_flag_o && packet_done_o))
    else $error("event and packet done on one result");

endmodule

bind ps2_mouse_cursor_tracker ps2mct_checker #(
  .COORD_BITS (COORD_BITS)
) u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .cursor_x_o    (cursor_x_o),
  .event_flag_o  (event_flag_o),
  .packet_done_o (packet_done_o)
);
`default_nettype wire

// ===== bench/ps2_mouse_cursor_tracker_tb.sv =====
// self-checking testbench for the ps2 mouse cursor tracker with a predictor and random stalls
`timescale 1ns / 1ps
module ps2_mouse_cursor_tracker_tb;
  import ps2mct_pkg::*;

  localparam mode_t MODE_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    mode_t       mode;
    logic [7:0]  rx;
    logic        ready;
    logic        aux;
    logic [31:0] tick;
  } mouse_req_t;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic        btn;
    logic        evt;
    logic        done;
  } cursor_res_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  reg_idx_t                 cfg_index_i = REG_SCREEN_WIDTH;
  logic [CFG_DATA_BITS-1:0] cfg_data_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  mode_t                    mode_i = MODE_BYTE;
  logic [7:0]               rx_byte_i = '0;
  logic                     data_ready_i = 1'b0;
  logic                     from_aux_i = 1'b0;
  logic [31:0]              now_tick_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [11:0]              cursor_x_o;
  logic [11:0]              cursor_y_o;
  logic                     left_button_o;
  logic                     event_flag_o;
  logic                     packet_done_o;

  ps2_mouse_cursor_tracker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .rx_byte_i     (rx_byte_i),
    .data_ready_i  (data_ready_i),
    .from_aux_i    (from_aux_i),
    .now_tick_i    (now_tick_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .cursor_x_o    (cursor_x_o),
    .cursor_y_o    (cursor_y_o),
    .left_button_o (left_button_o),
    .event_flag_o  (event_flag_o),
    .packet_done_o (packet_done_o)
  );

  always #6 clk_i = ~clk_i;

  mouse_req_t  mouse_reqs[$];
  cursor_res_t expected_cursor[$];
  mouse_req_t  cur_req;
  cursor_res_t want;
  int          send_gap;
  int          stall_left;
  int          mismatch_count = 0;
  int          cycle_count = 0;
  bit          gaps_on = 1'b1;
  logic [31:0] sys_tick = '0;

  // predictor copy of configuration and state
  logic [12:0] trk_width = SCREEN_WIDTH_RST;
  logic [12:0] trk_height = SCREEN_HEIGHT_RST;
  logic [7:0]  trk_limit = DELTA_LIMIT_RST;
  logic [15:0] trk_debounce = DEBOUNCE_TICKS_RST;
  int          trk_idx = 0;
  logic [7:0]  trk_hdr = '0;
  logic [7:0]  trk_xbyte = '0;
  int          trk_x = POS_X_RST;
  int          trk_y = POS_Y_RST;
  logic        trk_held = 1'b0;
  logic        trk_press = 1'b0;
  logic        trk_release = 1'b0;
  logic [31:0] trk_last_press = '0;

  function automatic int screen_extent(logic [12:0] s);
    int v;
    v = s;
    if (v == 0) v = 1;
    if (v > (1 << COORD_BITS_DEF)) v = 1 << COORD_BITS_DEF;
    return v;
  endfunction

  function automatic int limit_move(int d);
    int l;
    l = trk_limit;
    if (d > l) return l;
    if (d < -l) return -l;
    return d;
  endfunction

  function automatic int clamp_coord(int p, int size);
    if (p < 0) return 0;
    if (p >= size) return size - 1;
    return p;
  endfunction

  function automatic cursor_res_t track_cursor(mouse_req_t r);
    cursor_res_t res;
    int          w;
    int          h;
    int          dx;
    int          dy;
    logic        btn;
    logic [31:0] tick_gap;
    res.evt = 1'b0;
    res.done = 1'b0;
    case (r.mode)
      MODE_BYTE: begin
        if (r.ready && r.aux) begin
          if (trk_idx == 1) begin
            trk_xbyte = r.rx;
            trk_idx = 2;
          end else if (trk_idx == 2) begin
            trk_idx = 0;
            res.done = 1'b1;
            w = screen_extent(trk_width);
            h = screen_extent(trk_height);
            dx = int'(trk_xbyte) - (((trk_hdr & HDR_XSIGN) != 0) ? 256 : 0);
            dy = int'(r.rx) - (((trk_hdr & HDR_YSIGN) != 0) ? 256 : 0);
            btn = (trk_hdr & HDR_LEFT) != 0;
            if (btn && !trk_held) trk_press = 1'b1;
            if (!btn && trk_held) trk_release = 1'b1;
            trk_held = btn;
            // edge zeroing, y axis grows downward
            if ((trk_x <= 0 && dx < 0) || (trk_x >= w - 1 && dx > 0)) dx = 0;
            if ((trk_y <= 0 && dy > 0) || (trk_y >= h - 1 && dy < 0)) dy = 0;
            if ((trk_hdr & HDR_OVFL) == 0) begin
              trk_x = trk_x + limit_move(dx);
              trk_y = trk_y - limit_move(dy);
            end
            trk_x = clamp_coord(trk_x, w);
            trk_y = clamp_coord(trk_y, h);
          end else if ((r.rx & HDR_SYNC) != 0) begin
            trk_hdr = r.rx;
            trk_idx = 1;
          end else begin
            trk_idx = 0;
          end
        end
      end
      MODE_PRESS: begin
        if (trk_press) begin
          trk_press = 1'b0;
          tick_gap = r.tick - trk_last_press;
          if (tick_gap >= 32'(trk_debounce)) begin
            res.evt = 1'b1;
            trk_last_press = r.tick;
          end
        end
      end
      MODE_RELEASE: begin
        if (trk_release) begin
          trk_release = 1'b0;
          res.evt = 1'b1;
        end
      end
      default: ;
    endcase
    res.x = 12'(trk_x);
    res.y = 12'(trk_y);
    res.btn = trk_held;
    return res;
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid_i && !in_stall_o) expected_cursor.push_back(track_cursor(cur_req));
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (mouse_reqs.size() != 0) begin
          cur_req = mouse_reqs.pop_front();
          in_valid_i <= 1'b1;
          mode_i <= cur_req.mode;
          rx_byte_i <= cur_req.rx;
          data_ready_i <= cur_req.ready;
          from_aux_i <= cur_req.aux;
          now_tick_i <= cur_req.tick;
          if (gaps_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 18);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_cursor.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result x=%0d y=%0d btn=%0b evt=%0b done=%0b", $time,
                   cursor_x_o, cursor_y_o, left_button_o, event_flag_o, packet_done_o);
        end else begin
          want = expected_cursor.pop_front();
          if (cursor_x_o !== want.x || cursor_y_o !== want.y || left_button_o !== want.btn ||
              event_flag_o !== want.evt || packet_done_o !== want.done) begin
            mismatch_count++;
            $display("%0t: mismatch expected x=%0d y=%0d btn=%0b evt=%0b done=%0b", $time,
                     want.x, want.y, want.btn, want.evt, want.done);
            $display("%0t:          actual   x=%0d y=%0d btn=%0b evt=%0b done=%0b", $time,
                     cursor_x_o, cursor_y_o, left_button_o, event_flag_o, packet_done_o);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 17);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic void queue_req(mode_t m, logic [7:0] rx, logic rdy, logic aux,
                                    logic [31:0] tick);
    mouse_req_t r;
    r.mode = m;
    r.rx = rx;
    r.ready = rdy;
    r.aux = aux;
    r.tick = tick;
    mouse_reqs.push_back(r);
  endfunction

  function automatic void queue_byte(logic [7:0] rx);
    queue_req(MODE_BYTE, rx, 1'b1, 1'b1, $urandom);
  endfunction

  function automatic void queue_packet(logic [7:0] hdr, logic [7:0] xb, logic [7:0] yb);
    queue_byte(hdr);
    queue_byte(xb);
    queue_byte(yb);
  endfunction

  function automatic logic [31:0] next_tick();
    if ($urandom_range(0, 7) == 0) sys_tick = sys_tick + $urandom;
    else sys_tick = sys_tick + $urandom_range(0, 30);
    return sys_tick;
  endfunction

  task automatic wait_drained();
    while (mouse_reqs.size() != 0 || in_valid_i || expected_cursor.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_SCREEN_WIDTH:   trk_width = val[12:0];
      REG_SCREEN_HEIGHT:  trk_height = val[12:0];
      REG_DELTA_LIMIT:    trk_limit = val[7:0];
      REG_DEBOUNCE_TICKS: trk_debounce = val;
      default: ;
    endcase
  endtask

  task automatic random_phase(int n_items, bit mid_drain);
    int         sent;
    int         pick;
    int         v;
    logic [7:0] hdr;
    sent = 0;
    while (sent < n_items) begin
      if (mid_drain && sent >= n_items / 2) begin
        wait_drained();
        mid_drain = 1'b0;
      end
      pick = $urandom_range(0, 99);
      hdr = 8'($urandom) | HDR_SYNC;
      if ($urandom_range(0, 7) != 0) hdr = hdr & ~HDR_OVFL;
      if (pick < 55) begin
        queue_packet(hdr, 8'($urandom), 8'($urandom));
        sent += 3;
      end else if (pick < 75) begin
        queue_req(MODE_PRESS, 8'($urandom), 1'($urandom), 1'($urandom), next_tick());
        sent++;
      end else if (pick < 85) begin
        queue_req(MODE_RELEASE, 8'($urandom), 1'($urandom), 1'($urandom), next_tick());
        sent++;
      end else if (pick < 90) begin
        // byte ignored by the packet logic, not counted
        v = $urandom_range(0, 2);
        queue_req(MODE_BYTE, 8'($urandom), v[0], v[1], $urandom);
      end else if (pick < 94) begin
        queue_byte(8'($urandom) & ~HDR_SYNC);
        sent++;
      end else if (pick < 97) begin
        // header and x only, next byte completes a skewed packet
        queue_byte(hdr);
        queue_byte(8'($urandom));
        sent += 2;
      end else begin
        queue_req(MODE_UNUSED, 8'($urandom), 1'($urandom), 1'($urandom), $urandom);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    queue_byte(8'h00);
    queue_req(MODE_BYTE, 8'h08, 1'b0, 1'b1, 32'h0);
    queue_req(MODE_BYTE, 8'h08, 1'b1, 1'b0, 32'hFFFF_FFFF);
    queue_req(MODE_UNUSED, 8'hFF, 1'b1, 1'b1, 32'h0);
    queue_packet(8'h19, 8'h01, 8'h7F);
    queue_req(MODE_PRESS, 8'h00, 1'b1, 1'b1, 32'd20);
    queue_req(MODE_PRESS, 8'h00, 1'b1, 1'b1, 32'd21);
    queue_packet(8'hC8, 8'hFF, 8'hFF);
    queue_req(MODE_RELEASE, 8'h00, 1'b0, 1'b0, 32'd22);
    queue_req(MODE_RELEASE, 8'h00, 1'b0, 1'b0, 32'd23);
    queue_packet(8'h29, 8'h00, 8'h80);
    queue_req(MODE_PRESS, 8'h00, 1'b1, 1'b1, 32'd25);
    queue_packet(8'h4B, 8'h12, 8'h34);
    queue_packet(8'hF8, 8'h00, 8'h00);
    queue_req(MODE_RELEASE, 8'hFF, 1'b1, 1'b1, 32'd30);
    wait_drained();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin
          write_reg(REG_SCREEN_WIDTH, 16'd1);
          write_reg(REG_SCREEN_HEIGHT, 16'd1);
          write_reg(REG_DELTA_LIMIT, 16'd0);
          write_reg(REG_DEBOUNCE_TICKS, 16'd0);
        end
        1: begin
          write_reg(REG_SCREEN_WIDTH, 16'd0);
          write_reg(REG_SCREEN_HEIGHT, 16'd0);
          write_reg(REG_DELTA_LIMIT, 16'd255);
          write_reg(REG_DEBOUNCE_TICKS, 16'd65535);
        end
        2: begin
          write_reg(REG_SCREEN_WIDTH, 16'd8191);
          write_reg(REG_SCREEN_HEIGHT, 16'd4096);
          write_reg(REG_DELTA_LIMIT, 16'd255);
          write_reg(REG_DEBOUNCE_TICKS, 16'd1);
          sys_tick = 32'hFFFF_FF00;
        end
        3: begin
          write_reg(REG_SCREEN_WIDTH, 16'd16);
          write_reg(REG_SCREEN_HEIGHT, 16'd12);
          write_reg(REG_DELTA_LIMIT, 16'd7);
          write_reg(REG_DEBOUNCE_TICKS, 16'd20);
        end
        default: begin
          write_reg(REG_SCREEN_WIDTH, 16'($urandom_range(1, 4096)));
          write_reg(REG_SCREEN_HEIGHT, 16'($urandom_range(1, 4096)));
          write_reg(REG_DELTA_LIMIT, 16'($urandom_range(0, 255)));
          write_reg(REG_DEBOUNCE_TICKS, 16'($urandom_range(0, 40)));
          gaps_on = 1'b0;
        end
      endcase
      random_phase(110, p == 1);
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && expected_cursor.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

endmodule
